FILE: rtl/mecl_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mecl_pkg
// Shared types and constants for the exclusive multilevel LFU tag cache.
// ---------------------------------------------------------------------------
package mecl_pkg;

    typedef struct packed {
        logic        valid;
        logic [15:0] tag;
        logic [31:0] count;
    } entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_SEARCH,
        ST_HITWB,
        ST_PICK,
        ST_LOADWB,
        ST_SWAP_UP,
        ST_SWAP_LO,
        ST_DONE
    } state_t;

    localparam logic [2:0] LVL_L1   = 3'd0;
    localparam logic [2:0] LVL_L2   = 3'd1;
    localparam logic [2:0] LVL_L3   = 3'd2;
    localparam logic [2:0] LVL_MAIN = 3'd3;
    localparam logic [2:0] LVL_BACK = 3'd4;

    localparam logic [2:0] REG_L1_COST   = 3'd0;
    localparam logic [2:0] REG_L2_COST   = 3'd1;
    localparam logic [2:0] REG_L3_COST   = 3'd2;
    localparam logic [2:0] REG_MAIN_COST = 3'd3;
    localparam logic [2:0] REG_BACK_COST = 3'd4;

    // saturating use-count increment
    function automatic logic [31:0] bump(input logic [31:0] c);
        bump = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/mecl_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mecl_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mecl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/multilevel_exclusive_cache_lfu.sv
`default_nettype none
// ---------------------------------------------------------------------------
// multilevel_exclusive_cache_lfu
// Four-level exclusive tag hierarchy (L1, L2, L3, main) with LFU swaps.
// ---------------------------------------------------------------------------
// All four tag levels share one RAM, laid out L1, L2, L3, main, one entry
// (valid, tag, use count) per word, read one word per cycle. After reset a
// clearing pass writes every word before the first request is taken. A
// request then costs: address folding (ADDRESS_SPACE subtracted until the
// address is below it), a linear tag search up to the hit, one write-back,
// and for each level the block climbs an LFU scan of the level above and two
// swap writes; a backing-store miss adds a scan of main memory. The worst case
// is set by the single RAM read port. One request is in flight at a time; the
// result register lets the next one start while a result is still waiting.
module multilevel_exclusive_cache_lfu #(
    parameter int L1_ENTRIES    = 8,
    parameter int L2_ENTRIES    = 16,
    parameter int L3_ENTRIES    = 32,
    parameter int MAIN_ENTRIES  = 1024,
    parameter int ADDRESS_SPACE = 32768
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [4:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [14:0]                   block_address,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         hit_level,
    output logic [16:0]                        access_cost,
    output logic [$clog2(L1_ENTRIES)-1:0]      l1_slot,
    output logic [31:0]                        total_cost
);

    localparam int L2B   = L1_ENTRIES;
    localparam int L3B   = L1_ENTRIES + L2_ENTRIES;
    localparam int MB    = L1_ENTRIES + L2_ENTRIES + L3_ENTRIES;
    localparam int TOTAL = MB + MAIN_ENTRIES;
    localparam int AW    = $clog2(TOTAL);
    localparam int SW    = $clog2(L1_ENTRIES);
    localparam int EW    = $bits(mecl_pkg::entry_t);

    mecl_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [AW-1:0]    chk_idx_reg, chk_idx_next;
    logic [15:0]      addr_reg, addr_next;
    logic [2:0]       level_reg, level_next;
    logic [1:0]       pk_reg, pk_next;
    logic [AW-1:0]    pos_reg, pos_next;
    mecl_pkg::entry_t carry_reg, carry_next;
    mecl_pkg::entry_t cand_reg, cand_next;
    logic [AW-1:0]    cand_idx_reg, cand_idx_next;
    logic [31:0]      best_reg, best_next;
    logic [31:0]      sum_reg, sum_next;

    logic [15:0] cost0_reg, cost1_reg, cost2_reg, cost3_reg, cost4_reg;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        hit_level_reg;
    logic [16:0]       access_cost_reg;
    logic [SW-1:0]     l1_slot_reg;
    logic              out_load;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    mecl_pkg::entry_t  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [EW-1:0]     ram_rdata;
    mecl_pkg::entry_t  rd_ent;

    logic [AW-1:0]     pk_base, pk_end;
    logic              pk_le, pk_done;
    mecl_pkg::entry_t  pk_ent;
    logic [AW-1:0]     pk_idx;
    logic [2:0]        hit_lvl;
    logic [16:0]       cost;
    logic [32:0]       sum_wide;
    logic              cfg_wr;

    assign rd_ent = mecl_pkg::entry_t'(ram_rdata);

    mecl_ram #(
        .WIDTH(EW),
        .DEPTH(TOTAL)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(EW'(ram_wdata)),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost0_reg <= 16'd10;
            cost1_reg <= 16'd110;
            cost2_reg <= 16'd220;
            cost3_reg <= 16'd1110;
            cost4_reg <= 16'd2150;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                mecl_pkg::REG_L1_COST:   cost0_reg <= pwdata[15:0];
                mecl_pkg::REG_L2_COST:   cost1_reg <= pwdata[15:0];
                mecl_pkg::REG_L3_COST:   cost2_reg <= pwdata[15:0];
                mecl_pkg::REG_MAIN_COST: cost3_reg <= pwdata[15:0];
                mecl_pkg::REG_BACK_COST: cost4_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            mecl_pkg::REG_L1_COST:   prdata = {16'd0, cost0_reg};
            mecl_pkg::REG_L2_COST:   prdata = {16'd0, cost1_reg};
            mecl_pkg::REG_L3_COST:   prdata = {16'd0, cost2_reg};
            mecl_pkg::REG_MAIN_COST: prdata = {16'd0, cost3_reg};
            mecl_pkg::REG_BACK_COST: prdata = {16'd0, cost4_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // scan bounds of the level being picked from
    always_comb
    begin
        case (pk_reg)
            2'd0:
            begin
                pk_base = AW'(0);
                pk_end  = AW'(L2B - 1);
            end
            2'd1:
            begin
                pk_base = AW'(L2B);
                pk_end  = AW'(L3B - 1);
            end
            2'd2:
            begin
                pk_base = AW'(L3B);
                pk_end  = AW'(MB - 1);
            end
            default:
            begin
                pk_base = AW'(MB);
                pk_end  = AW'(TOTAL - 1);
            end
        endcase
    end

    // LFU step: ties go to the later entry, an empty slot at or below the minimum ends the scan
    assign pk_le   = rd_ent.count <= best_reg;
    assign pk_ent  = pk_le ? rd_ent : cand_reg;
    assign pk_idx  = pk_le ? chk_idx_reg : cand_idx_reg;
    assign pk_done = chk_vld_reg & ((pk_le & ~rd_ent.valid) | (chk_idx_reg == pk_end));

    always_comb
    begin
        if (chk_idx_reg < AW'(L2B))
            hit_lvl = mecl_pkg::LVL_L1;
        else if (chk_idx_reg < AW'(L3B))
            hit_lvl = mecl_pkg::LVL_L2;
        else if (chk_idx_reg < AW'(MB))
            hit_lvl = mecl_pkg::LVL_L3;
        else
            hit_lvl = mecl_pkg::LVL_MAIN;
    end

    always_comb
    begin
        case (level_reg)
            mecl_pkg::LVL_L1:   cost = {1'b0, cost0_reg};
            mecl_pkg::LVL_L2:   cost = {1'b0, cost1_reg};
            mecl_pkg::LVL_L3:   cost = {1'b0, cost2_reg};
            mecl_pkg::LVL_MAIN: cost = {1'b0, cost3_reg};
            default:            cost = {1'b0, cost3_reg} + {1'b0, cost4_reg};
        endcase
    end

    assign sum_wide = {1'b0, sum_reg} + {16'd0, cost};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mecl_pkg::ST_CLEAR;
            idx_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            level_reg     <= '0;
            pk_reg        <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            chk_vld_reg   <= chk_vld_next;
            level_reg     <= level_next;
            pk_reg        <= pk_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        addr_reg     <= addr_next;
        pos_reg      <= pos_next;
        carry_reg    <= carry_next;
        cand_reg     <= cand_next;
        cand_idx_reg <= cand_idx_next;
        best_reg     <= best_next;
        if (out_load)
        begin
            hit_level_reg   <= level_reg;
            access_cost_reg <= cost;
            l1_slot_reg     <= pos_reg[SW-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = idx_reg;
        addr_next      = addr_reg;
        level_next     = level_reg;
        pk_next        = pk_reg;
        pos_next       = pos_reg;
        carry_next     = carry_reg;
        cand_next      = cand_reg;
        cand_idx_next  = cand_idx_reg;
        best_next      = best_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg & out_stall;
        out_load       = 1'b0;
        in_stall       = 1'b1;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = carry_reg;
        ram_raddr      = idx_reg;

        case (state_reg)
            mecl_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = '0;
                if (idx_reg == AW'(TOTAL - 1))
                begin
                    state_next = mecl_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            mecl_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    addr_next  = {1'b0, block_address};
                    state_next = mecl_pkg::ST_REDUCE;
                end
            end

            mecl_pkg::ST_REDUCE:
            begin
                if ({1'b0, addr_reg} >= 17'(ADDRESS_SPACE))
                begin
                    addr_next = 16'({1'b0, addr_reg} - 17'(ADDRESS_SPACE));
                end
                else
                begin
                    idx_next   = '0;
                    state_next = mecl_pkg::ST_SEARCH;
                end
            end

            mecl_pkg::ST_SEARCH:
            begin
                chk_vld_next = 1'b1;
                if (idx_reg != AW'(TOTAL - 1))
                    idx_next = idx_reg + AW'(1);
                if (chk_vld_reg)
                begin
                    if (rd_ent.valid && rd_ent.tag == addr_reg)
                    begin
                        chk_vld_next = 1'b0;
                        level_next   = hit_lvl;
                        pos_next     = chk_idx_reg;
                        carry_next   = rd_ent;
                        if (hit_lvl == mecl_pkg::LVL_L1)
                            carry_next.count = mecl_pkg::bump(mecl_pkg::bump(rd_ent.count));
                        else
                            carry_next.count = mecl_pkg::bump(rd_ent.count);
                        state_next   = mecl_pkg::ST_HITWB;
                    end
                    else if (chk_idx_reg == AW'(TOTAL - 1))
                    begin
                        // miss everywhere: pick a main memory victim
                        chk_vld_next = 1'b0;
                        level_next   = mecl_pkg::LVL_BACK;
                        pk_next      = mecl_pkg::LVL_MAIN[1:0];
                        idx_next     = AW'(MB);
                        best_next    = 32'hFFFF_FFFF;
                        state_next   = mecl_pkg::ST_PICK;
                    end
                end
            end

            mecl_pkg::ST_HITWB:
            begin
                ram_we = 1'b1;
                if (level_reg == mecl_pkg::LVL_L1)
                begin
                    state_next = mecl_pkg::ST_DONE;
                end
                else
                begin
                    pk_next    = level_reg[1:0] - 2'd1;
                    state_next = mecl_pkg::ST_PICK;
                end
            end

            mecl_pkg::ST_PICK:
            begin
                if (chk_vld_reg && pk_le)
                begin
                    best_next     = rd_ent.count;
                    cand_next     = rd_ent;
                    cand_idx_next = chk_idx_reg;
                end
                if (pk_done)
                begin
                    cand_next     = pk_ent;
                    cand_idx_next = pk_idx;
                    if (pk_reg == mecl_pkg::LVL_MAIN[1:0])
                    begin
                        carry_next = '{valid: 1'b1, tag: addr_reg, count: pk_ent.count};
                        pos_next   = pk_idx;
                        state_next = mecl_pkg::ST_LOADWB;
                    end
                    else
                    begin
                        state_next = mecl_pkg::ST_SWAP_UP;
                    end
                end
                else if (chk_vld_reg || idx_reg != pk_base || best_reg != 32'hFFFF_FFFF)
                begin
                    chk_vld_next = 1'b1;
                    if (idx_reg != pk_end)
                        idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    chk_vld_next = 1'b1;
                    idx_next     = idx_reg + AW'(1);
                end
            end

            mecl_pkg::ST_LOADWB:
            begin
                ram_we     = 1'b1;
                pk_next    = mecl_pkg::LVL_L3[1:0];
                state_next = mecl_pkg::ST_PICK;
            end

            mecl_pkg::ST_SWAP_UP:
            begin
                ram_we           = 1'b1;
                ram_waddr        = cand_idx_reg;
                ram_wdata        = carry_reg;
                ram_wdata.count  = mecl_pkg::bump(carry_reg.count);
                carry_next.count = mecl_pkg::bump(carry_reg.count);
                state_next       = mecl_pkg::ST_SWAP_LO;
            end

            mecl_pkg::ST_SWAP_LO:
            begin
                ram_we          = 1'b1;
                ram_waddr       = pos_reg;
                ram_wdata       = cand_reg;
                ram_wdata.count = mecl_pkg::bump(cand_reg.count);
                pos_next        = cand_idx_reg;
                if (pk_reg == 2'd0)
                begin
                    state_next = mecl_pkg::ST_DONE;
                end
                else
                begin
                    pk_next    = pk_reg - 2'd1;
                    state_next = mecl_pkg::ST_PICK;
                end
            end

            mecl_pkg::ST_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    sum_next       = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
                    state_next     = mecl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mecl_pkg::ST_IDLE;
            end
        endcase

        // every scan starts from the level base with a fresh minimum
        if ((state_next == mecl_pkg::ST_PICK) && (state_reg != mecl_pkg::ST_PICK))
        begin
            best_next    = 32'hFFFF_FFFF;
            chk_vld_next = 1'b0;
            case (pk_next)
                2'd0:    idx_next = AW'(0);
                2'd1:    idx_next = AW'(L2B);
                2'd2:    idx_next = AW'(L3B);
                default: idx_next = AW'(MB);
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit_level   = hit_level_reg;
    assign access_cost = access_cost_reg;
    assign l1_slot     = l1_slot_reg;
    assign total_cost  = sum_reg;

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == mecl_pkg::ST_DONE))
        else $error("result raised outside completion");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit_level <= mecl_pkg::LVL_BACK))
        else $error("hit level out of range");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_waddr <= AW'(TOTAL - 1)))
        else $error("tag RAM write beyond last entry");

    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (sum_reg >= $past(sum_reg)))
        else $error("running cost decreased");

endmodule
`default_nettype wire

FILE: sim/multilevel_exclusive_cache_lfu_test.sv
// ---------------------------------------------------------------------------
// multilevel_exclusive_cache_lfu_test
// Drives block addresses into the exclusive LFU tag hierarchy, predicts hit
// level, cost, L1 slot and running total, and compares every result.
// ---------------------------------------------------------------------------
module multilevel_exclusive_cache_lfu_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_L1   = 8;
    localparam int N_L2   = 16;
    localparam int N_L3   = 32;
    localparam int N_MAIN = 1024;
    localparam int N_ALL  = N_L1 + N_L2 + N_L3 + N_MAIN;
    localparam int BASE_L2   = N_L1;
    localparam int BASE_L3   = N_L1 + N_L2;
    localparam int BASE_MAIN = N_L1 + N_L2 + N_L3;
    localparam int N_RANDOM  = 260;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  level;
        logic [16:0] cost;
        logic [2:0]  slot;
        logic [31:0] total;
    } access_result_t;

    typedef struct {
        logic [14:0] addr;
        bit          has_expected;
        logic [2:0]  level;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [14:0] block_address = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] hit_level;
    logic [16:0] access_cost;
    logic [2:0] l1_slot;
    logic [31:0] total_cost;

    // predictor state: flat tag store laid out L1, L2, L3, main
    logic        tag_valid [N_ALL];
    logic [15:0] tag_value [N_ALL];
    logic [31:0] use_count [N_ALL];
    logic [31:0] running_cost;
    logic [15:0] level_cost [5];

    access_result_t pending_results[$];
    int  errors = 0;
    int  out_wait = 0;

    multilevel_exclusive_cache_lfu uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .block_address(block_address),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit_level(hit_level), .access_cost(access_cost),
        .l1_slot(l1_slot), .total_cost(total_cost)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int level_base(int k);
        case (k)
            0: return 0;
            1: return BASE_L2;
            2: return BASE_L3;
            default: return BASE_MAIN;
        endcase
    endfunction

    function automatic int level_size(int k);
        case (k)
            0: return N_L1;
            1: return N_L2;
            2: return N_L3;
            default: return N_MAIN;
        endcase
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] c);
        return (c == CNT_MAX) ? c : c + 32'd1;
    endfunction

    // last entry with the lowest count, or the first empty one at or below it
    function automatic int lfu_victim(int k);
        logic [31:0] lowest;
        int          pick;
        int          base;
        lowest = CNT_MAX;
        pick = 0;
        base = level_base(k);
        for (int i = 0; i < level_size(k); i++)
        begin
            if (use_count[base + i] <= lowest)
            begin
                if (!tag_valid[base + i])
                    return i;
                lowest = use_count[base + i];
                pick = i;
            end
        end
        return pick;
    endfunction

    function automatic access_result_t predict_access(logic [14:0] addr_in);
        access_result_t r;
        logic [15:0] addr;
        int level;
        int pos;
        int k;
        int up_pos;
        int a;
        int b;
        logic        tv;
        logic [15:0] tt;
        logic [31:0] tc;
        logic [16:0] cost;
        addr = {1'b0, addr_in};
        level = 4;
        pos = 0;
        for (k = 0; k < 4 && level == 4; k++)
        begin
            for (int i = 0; i < level_size(k); i++)
            begin
                if (tag_valid[level_base(k) + i] && tag_value[level_base(k) + i] == addr)
                begin
                    use_count[level_base(k) + i] = sat_inc(use_count[level_base(k) + i]);
                    level = k;
                    pos = i;
                    break;
                end
            end
        end
        if (level == 0)
            use_count[pos] = sat_inc(use_count[pos]);
        else
        begin
            if (level == 4)
            begin
                pos = lfu_victim(3);
                tag_value[BASE_MAIN + pos] = addr;
                tag_valid[BASE_MAIN + pos] = 1'b1;
            end
            k = (level > 3) ? 3 : level;
            while (k > 0)
            begin
                up_pos = lfu_victim(k - 1);
                a = level_base(k - 1) + up_pos;
                b = level_base(k) + pos;
                tv = tag_valid[a]; tt = tag_value[a]; tc = use_count[a];
                tag_valid[a] = tag_valid[b]; tag_value[a] = tag_value[b];
                use_count[a] = use_count[b];
                tag_valid[b] = tv; tag_value[b] = tt; use_count[b] = tc;
                use_count[b] = sat_inc(use_count[b]);
                use_count[a] = sat_inc(use_count[a]);
                pos = up_pos;
                k--;
            end
        end
        if (level < 4)
            cost = {1'b0, level_cost[level]};
        else
            cost = {1'b0, level_cost[3]} + {1'b0, level_cost[4]};
        if (running_cost > CNT_MAX - {15'd0, cost})
            running_cost = CNT_MAX;
        else
            running_cost = running_cost + {15'd0, cost};
        r.level = level[2:0];
        r.cost = cost;
        r.slot = pos[2:0];
        r.total = running_cost;
        return r;
    endfunction

    task automatic write_cost(logic [2:0] index, logic [15:0] value);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {index, 2'b00}; pwdata <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        level_cost[index] = value;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2500) @(posedge clk);
    endtask

    task automatic send_access(logic [14:0] addr, bit has_expected, logic [2:0] level);
        access_result_t r;
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        // drop valid only while idling between requests
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        block_address <= addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = predict_access(addr);
        if (has_expected && r.level != level)
        begin
            $display("%0t predictor level for %h: expected %0d actual %0d",
                     $time, addr, level, r.level);
            errors++;
        end
        pending_results.push_back(r);
        @(negedge clk);
    endtask

    // hold each result for a drawn number of cycles before taking it
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                out_wait = $urandom_range(0, 10);
            if (out_valid && out_wait > 0)
            begin
                out_stall <= 1'b1;
                out_wait = out_wait - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        access_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: level %0d", $time, hit_level);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (hit_level !== exp_r.level)
                begin
                    $display("%0t hit_level expected %0d actual %0d",
                             $time, exp_r.level, hit_level);
                    errors++;
                end
                if (access_cost !== exp_r.cost)
                begin
                    $display("%0t access_cost expected %0d actual %0d",
                             $time, exp_r.cost, access_cost);
                    errors++;
                end
                if (l1_slot !== exp_r.slot)
                begin
                    $display("%0t l1_slot expected %0d actual %0d",
                             $time, exp_r.slot, l1_slot);
                    errors++;
                end
                if (total_cost !== exp_r.total)
                begin
                    $display("%0t total_cost expected %0d actual %0d",
                             $time, exp_r.total, total_cost);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #200ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        directed_row_t rows[$];
        logic [14:0] addr;
        int pick;
        for (int i = 0; i < N_ALL; i++)
        begin
            tag_valid[i] = 1'b0;
            tag_value[i] = '0;
            use_count[i] = '0;
        end
        running_cost = '0;
        level_cost[mecl_pkg::REG_L1_COST] = 16'd10;
        level_cost[mecl_pkg::REG_L2_COST] = 16'd110;
        level_cost[mecl_pkg::REG_L3_COST] = 16'd220;
        level_cost[mecl_pkg::REG_MAIN_COST] = 16'd1110;
        level_cost[mecl_pkg::REG_BACK_COST] = 16'd2150;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // extremes of the address, full misses, then hits at L1
        rows.push_back('{15'h0000, 1'b1, mecl_pkg::LVL_BACK});
        rows.push_back('{15'h7FFF, 1'b1, mecl_pkg::LVL_BACK});
        rows.push_back('{15'h5555, 1'b1, mecl_pkg::LVL_BACK});
        rows.push_back('{15'h2AAA, 1'b1, mecl_pkg::LVL_BACK});
        rows.push_back('{15'h0000, 1'b1, mecl_pkg::LVL_L1});
        rows.push_back('{15'h7FFF, 1'b1, mecl_pkg::LVL_L1});
        // overfill L1 so older blocks sink, then recall them
        for (int i = 1; i <= 14; i++)
            rows.push_back('{i[14:0] * 15'd97, 1'b0, mecl_pkg::LVL_L1});
        rows.push_back('{15'h5555, 1'b0, mecl_pkg::LVL_L1});
        rows.push_back('{15'h2AAA, 1'b0, mecl_pkg::LVL_L1});
        rows.push_back('{15'd97, 1'b0, mecl_pkg::LVL_L1});

        foreach (rows[i])
            send_access(rows[i].addr, rows[i].has_expected, rows[i].level);

        // hold until every result has arrived, then move costs to the extremes
        wait_idle();
        write_cost(mecl_pkg::REG_L1_COST, 16'hFFFF);
        write_cost(mecl_pkg::REG_L2_COST, 16'hFFFF);
        write_cost(mecl_pkg::REG_L3_COST, 16'hFFFF);
        write_cost(mecl_pkg::REG_MAIN_COST, 16'hFFFF);
        write_cost(mecl_pkg::REG_BACK_COST, 16'hFFFF);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 80 || n == 170)
            begin
                wait_idle();
                for (int r = 0; r < 5; r++)
                    write_cost(r[2:0], (n == 80) ? 16'd0 : 16'($urandom));
            end
            pick = $urandom_range(0, 9);
            // mostly a small working set so blocks climb and sink through levels
            if (pick < 7)
                addr = 15'($urandom_range(0, 60)) * 15'd131;
            else
                addr = 15'($urandom);
            send_access(addr, 1'b0, mecl_pkg::LVL_L1);
        end

        wait_idle();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
